// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/lprf_pkg.sv -----
// ----------------------------------------------------------------------------
// lprf_pkg
// Constants, codes and controller/datapath interface types of the record FIFO.
// ----------------------------------------------------------------------------
package lprf_pkg;

	localparam int CAP_BYTES    = 1024;
	localparam int MAX_RECORD   = 64;
	localparam int HEADER_BYTES = 4;

	localparam int ADDR_W     = $clog2(CAP_BYTES);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int LEN_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int OP_W       = 3;
	localparam int ST_W       = 3;
	localparam int HDR_W      = 8 * HEADER_BYTES;
	localparam int HDR_IDX_W  = $clog2(HEADER_BYTES);

	localparam int IN_FIELDS_W  = BYTE_W + LEN_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = BYTE_W + LEN_W + 2 * CNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_COMMIT = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
	localparam logic [OP_W-1:0] OP_RESET  = 3'd4;

	localparam logic [ST_W-1:0] ST_COMMITTED = 3'd0;
	localparam logic [ST_W-1:0] ST_REJECTED  = 3'd1;
	localparam logic [ST_W-1:0] ST_BODY      = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [ST_W-1:0] ST_DROPPED   = 3'd4;
	localparam logic [ST_W-1:0] ST_PEEK      = 3'd5;
	localparam logic [ST_W-1:0] ST_RESET     = 3'd6;
	localparam logic [ST_W-1:0] ST_ZERO_LEN  = 3'd7;

	typedef struct packed {
		logic            do_append;
		logic            commit_eval;
		logic            ring_clr;
		logic            cap_load;
		logic            idx_clr;
		logic            idx_inc;
		logic            hdr_wr;
		logic            wc_adv;
		logic            hdr_cap;
		logic            rc_adv;
		logic            body_base;
		logic            rd_body;
		logic            res_load;
		logic            res_len_hdr;
		logic            body_load;
		logic [ST_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic used_lt_hdr;
		logic commit_ok;
		logic hdr_ok;
		logic oversize;
		logic zero_len;
		logic idx_zero;
		logic idx_hdr_end;
		logic idx_hdr_done;
		logic body_last;
		logic out_free;
	} stat_t;

endpackage

// ----- rtl/length_prefixed_record_fifo_top.sv -----
// Append beats are taken one per cycle while idle, with no result; OP_RESET gives a result.
// Commit answers rejected, or writes the four header bytes and then answers committed.
// Read and peek fetch the header over the one RAM read port, then give a single-beat
// result or, for a read, body beats via the address and data states (registered read).
// A read or peek with less than a header held answers without reading the ring.
// Reset clears counters, staged record, reserve and output valid; ring bytes are not cleared.
// ----------------------------------------------------------------------------
// length_prefixed_record_fifo_top
// Byte ring of length-prefixed records with staged append, commit and read.
// ----------------------------------------------------------------------------
module length_prefixed_record_fifo_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] data_byte, [14:8] reader_capacity, [15] zero
	input  logic [lprf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [2:0] opcode
	input  logic [lprf_pkg::OP_W-1:0]         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] out_byte, [14:8] record_length, [25:15] used_bytes, [36:26] free_bytes
	output logic [lprf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [2:0] status
	output logic [lprf_pkg::ST_W-1:0]         m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lprf_pkg::CNT_W-1:0]        cfg_data
);

	lprf_pkg::cmd_t              cmd;
	lprf_pkg::stat_t             stat;
	logic [lprf_pkg::BYTE_W-1:0] out_byte;
	logic [lprf_pkg::LEN_W-1:0]  out_len;
	logic [lprf_pkg::CNT_W-1:0]  out_used, out_free;

	assign cfg_ready = 1'b1;

	lprf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_op   (s_axis_tuser),
		.stat    (stat),
		.cmd     (cmd)
	);

	lprf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_byte   (s_axis_tdata[lprf_pkg::BYTE_W-1:0]),
		.in_cap    (s_axis_tdata[lprf_pkg::IN_FIELDS_W-1:lprf_pkg::BYTE_W]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_status(m_axis_tuser),
		.out_byte  (out_byte),
		.out_last  (m_axis_tlast),
		.out_len   (out_len),
		.out_used  (out_used),
		.out_free  (out_free)
	);

	assign m_axis_tdata = {{lprf_pkg::OUT_PAD_W{1'b0}}, out_free, out_used, out_len, out_byte};

endmodule

// ----- rtl/lprf_ram.sv -----
// ----------------------------------------------------------------------------
// lprf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lprf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/lprf_datapath.sv -----
// ----------------------------------------------------------------------------
// lprf_datapath
// Ring store, counters, staged record, header capture and result register.
// ----------------------------------------------------------------------------
module lprf_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lprf_pkg::cmd_t               cmd,
	output lprf_pkg::stat_t              stat,
	input  logic [lprf_pkg::BYTE_W-1:0]  in_byte,
	input  logic [lprf_pkg::LEN_W-1:0]   in_cap,
	input  logic                         cfg_valid,
	input  logic [lprf_pkg::CNT_W-1:0]   cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lprf_pkg::ST_W-1:0]    out_status,
	output logic [lprf_pkg::BYTE_W-1:0]  out_byte,
	output logic                         out_last,
	output logic [lprf_pkg::LEN_W-1:0]   out_len,
	output logic [lprf_pkg::CNT_W-1:0]   out_used,
	output logic [lprf_pkg::CNT_W-1:0]   out_free
);

	localparam int NW = lprf_pkg::CNT_W + 1;

	logic [lprf_pkg::CNT_W-1:0]     wc_q, rc_q, reserve_q;
	logic [lprf_pkg::LEN_W-1:0]     staged_len_q, cap_q, len_q, idx_q;
	logic                           staged_fail_q;
	logic [lprf_pkg::ADDR_W-1:0]    base_q;
	logic [lprf_pkg::HDR_W-1:0]     hdr_q;
	logic                           out_valid_q;

	logic [lprf_pkg::CNT_W-1:0]     used, space, room, used_m_hdr;
	logic [NW-1:0]                  need_app, need_cmt;
	logic                           append_bad, append_write;
	logic [lprf_pkg::HDR_IDX_W-1:0] hdr_sel;
	logic [lprf_pkg::LEN_W:0]       idx_next;

	logic                           ram_we;
	logic [lprf_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
	logic [lprf_pkg::BYTE_W-1:0]    ram_wdata, ram_rdata;

	assign used       = wc_q - rc_q;
	assign space      = lprf_pkg::CNT_W'(lprf_pkg::CAP_BYTES) - used;
	assign room       = space - reserve_q;
	assign used_m_hdr = used - lprf_pkg::CNT_W'(lprf_pkg::HEADER_BYTES);
	assign need_app   = NW'(lprf_pkg::HEADER_BYTES + 1) + NW'(staged_len_q);
	assign need_cmt   = NW'(lprf_pkg::HEADER_BYTES) + NW'(staged_len_q);
	assign append_bad = (staged_len_q >= lprf_pkg::LEN_W'(lprf_pkg::MAX_RECORD)) ||
		(need_app > {1'b0, space});
	assign append_write = cmd.do_append && !staged_fail_q && !append_bad;
	assign hdr_sel    = lprf_pkg::HDR_IDX_W'(idx_q - lprf_pkg::LEN_W'(1));
	assign idx_next   = {1'b0, idx_q} + (lprf_pkg::LEN_W + 1)'(1);

	assign stat.used_lt_hdr  = used < lprf_pkg::CNT_W'(lprf_pkg::HEADER_BYTES);
	assign stat.commit_ok    = !staged_fail_q &&
		(staged_len_q <= lprf_pkg::LEN_W'(lprf_pkg::MAX_RECORD)) &&
		(space >= reserve_q) && ({1'b0, room} >= need_cmt);
	assign stat.hdr_ok       = hdr_q <= lprf_pkg::HDR_W'(used_m_hdr);
	assign stat.oversize     = (hdr_q > lprf_pkg::HDR_W'(cap_q)) ||
		(hdr_q > lprf_pkg::HDR_W'(lprf_pkg::MAX_RECORD));
	assign stat.zero_len     = hdr_q == '0;
	assign stat.idx_zero     = idx_q == '0;
	assign stat.idx_hdr_end  = idx_q == lprf_pkg::LEN_W'(lprf_pkg::HEADER_BYTES - 1);
	assign stat.idx_hdr_done = idx_q == lprf_pkg::LEN_W'(lprf_pkg::HEADER_BYTES);
	assign stat.body_last    = idx_next == {1'b0, len_q};
	assign stat.out_free     = !out_valid_q || out_ready;

	assign ram_we    = append_write || cmd.hdr_wr;
	assign ram_waddr = cmd.hdr_wr ?
		(wc_q[lprf_pkg::ADDR_W-1:0] + lprf_pkg::ADDR_W'(idx_q)) :
		(wc_q[lprf_pkg::ADDR_W-1:0] + lprf_pkg::ADDR_W'(lprf_pkg::HEADER_BYTES) +
		lprf_pkg::ADDR_W'(staged_len_q));
	assign ram_wdata = cmd.hdr_wr ?
		(stat.idx_zero ? lprf_pkg::BYTE_W'(len_q) : '0) : in_byte;
	assign ram_raddr = cmd.rd_body ? (base_q + lprf_pkg::ADDR_W'(idx_q)) :
		(rc_q[lprf_pkg::ADDR_W-1:0] + lprf_pkg::ADDR_W'(idx_q));

	lprf_ram #(
		.WIDTH(lprf_pkg::BYTE_W),
		.DEPTH(lprf_pkg::CAP_BYTES)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q          <= '0;
			rc_q          <= '0;
			staged_len_q  <= '0;
			staged_fail_q <= 1'b0;
			reserve_q     <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				reserve_q <= cfg_data;
			end
			if (cmd.ring_clr || cmd.commit_eval) begin
				staged_len_q  <= '0;
				staged_fail_q <= 1'b0;
			end else if (cmd.do_append && !staged_fail_q) begin
				if (append_bad) begin
					staged_fail_q <= 1'b1;
				end else begin
					staged_len_q <= staged_len_q + lprf_pkg::LEN_W'(1);
				end
			end
			if (cmd.ring_clr) begin
				wc_q <= '0;
			end else if (cmd.wc_adv) begin
				wc_q <= wc_q + lprf_pkg::CNT_W'(lprf_pkg::HEADER_BYTES) +
					lprf_pkg::CNT_W'(len_q);
			end
			if (cmd.ring_clr) begin
				rc_q <= '0;
			end else if (cmd.rc_adv) begin
				rc_q <= rc_q + lprf_pkg::CNT_W'(lprf_pkg::HEADER_BYTES) +
					hdr_q[lprf_pkg::CNT_W-1:0];
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_next[lprf_pkg::LEN_W-1:0];
			end
			if (cmd.res_load || cmd.body_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_load) begin
			cap_q <= in_cap;
		end
		if (cmd.commit_eval) begin
			len_q <= staged_len_q;
		end else if (cmd.body_base) begin
			len_q <= hdr_q[lprf_pkg::LEN_W-1:0];
		end
		if (cmd.body_base) begin
			base_q <= rc_q[lprf_pkg::ADDR_W-1:0] + lprf_pkg::ADDR_W'(lprf_pkg::HEADER_BYTES);
		end
		if (cmd.hdr_cap) begin
			hdr_q[hdr_sel*8 +: 8] <= ram_rdata;
		end
		if (cmd.res_load) begin
			out_status <= cmd.res_status;
			out_byte   <= '0;
			out_last   <= 1'b1;
			out_len    <= cmd.res_len_hdr ? hdr_q[lprf_pkg::LEN_W-1:0] : '0;
			out_used   <= used;
			out_free   <= space;
		end else if (cmd.body_load) begin
			out_status <= lprf_pkg::ST_BODY;
			out_byte   <= ram_rdata;
			out_last   <= stat.body_last;
			out_len    <= len_q;
			out_used   <= used;
			out_free   <= space;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/lprf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lprf_ctrl
// Sequencer for commit, header read, body delivery and single-beat results.
// ----------------------------------------------------------------------------
module lprf_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lprf_pkg::OP_W-1:0]  in_op,
	input  lprf_pkg::stat_t            stat,
	output lprf_pkg::cmd_t             cmd
);

	localparam logic [2:0] S_IDLE      = 3'd0;
	localparam logic [2:0] S_COMMIT    = 3'd1;
	localparam logic [2:0] S_HDR_WR    = 3'd2;
	localparam logic [2:0] S_HDR_RD    = 3'd3;
	localparam logic [2:0] S_HDR_EVAL  = 3'd4;
	localparam logic [2:0] S_BODY_ADDR = 3'd5;
	localparam logic [2:0] S_BODY_DATA = 3'd6;
	localparam logic [2:0] S_EMIT      = 3'd7;

	logic [2:0]                state_q, state_d;
	logic                      peek_q, peek_d;
	logic [lprf_pkg::ST_W-1:0] pend_status_q, pend_status_d;
	logic                      pend_hdr_q, pend_hdr_d;

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		peek_d        = peek_q;
		pend_status_d = pend_status_q;
		pend_hdr_d    = pend_hdr_q;
		in_ready      = state_q == S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_op)
						lprf_pkg::OP_APPEND: begin
							cmd.do_append = 1'b1;
						end
						lprf_pkg::OP_COMMIT: begin
							state_d = S_COMMIT;
						end
						lprf_pkg::OP_READ, lprf_pkg::OP_PEEK: begin
							cmd.cap_load = 1'b1;
							cmd.idx_clr  = 1'b1;
							peek_d       = in_op == lprf_pkg::OP_PEEK;
							if (stat.used_lt_hdr) begin
								pend_status_d = (in_op == lprf_pkg::OP_PEEK) ?
									lprf_pkg::ST_PEEK : lprf_pkg::ST_EMPTY;
								pend_hdr_d    = 1'b0;
								state_d       = S_EMIT;
							end else begin
								state_d = S_HDR_RD;
							end
						end
						lprf_pkg::OP_RESET: begin
							cmd.ring_clr  = 1'b1;
							pend_status_d = lprf_pkg::ST_RESET;
							pend_hdr_d    = 1'b0;
							state_d       = S_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			S_COMMIT: begin
				cmd.commit_eval = 1'b1;
				cmd.idx_clr     = 1'b1;
				if (stat.commit_ok) begin
					state_d = S_HDR_WR;
				end else begin
					pend_status_d = lprf_pkg::ST_REJECTED;
					pend_hdr_d    = 1'b0;
					state_d       = S_EMIT;
				end
			end
			S_HDR_WR: begin
				cmd.hdr_wr  = 1'b1;
				cmd.idx_inc = 1'b1;
				if (stat.idx_hdr_end) begin
					cmd.wc_adv    = 1'b1;
					pend_status_d = lprf_pkg::ST_COMMITTED;
					pend_hdr_d    = 1'b0;
					state_d       = S_EMIT;
				end
			end
			S_HDR_RD: begin
				cmd.hdr_cap = !stat.idx_zero;
				if (stat.idx_hdr_done) begin
					state_d = S_HDR_EVAL;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_HDR_EVAL: begin
				if (peek_q) begin
					pend_status_d = lprf_pkg::ST_PEEK;
					pend_hdr_d    = stat.hdr_ok;
					state_d       = S_EMIT;
				end else if (!stat.hdr_ok) begin
					pend_status_d = lprf_pkg::ST_EMPTY;
					pend_hdr_d    = 1'b0;
					state_d       = S_EMIT;
				end else begin
					cmd.rc_adv    = 1'b1;
					cmd.body_base = 1'b1;
					cmd.idx_clr   = 1'b1;
					if (stat.oversize) begin
						pend_status_d = lprf_pkg::ST_DROPPED;
						pend_hdr_d    = 1'b1;
						state_d       = S_EMIT;
					end else if (stat.zero_len) begin
						pend_status_d = lprf_pkg::ST_ZERO_LEN;
						pend_hdr_d    = 1'b0;
						state_d       = S_EMIT;
					end else begin
						state_d = S_BODY_ADDR;
					end
				end
			end
			S_BODY_ADDR: begin
				cmd.rd_body = 1'b1;
				state_d     = S_BODY_DATA;
			end
			S_BODY_DATA: begin
				cmd.rd_body = 1'b1;
				if (stat.out_free) begin
					cmd.body_load = 1'b1;
					cmd.idx_inc   = 1'b1;
					state_d       = stat.body_last ? S_IDLE : S_BODY_ADDR;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.res_load    = 1'b1;
					cmd.res_status  = pend_status_q;
					cmd.res_len_hdr = pend_hdr_q;
					state_d         = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			peek_q        <= 1'b0;
			pend_status_q <= lprf_pkg::ST_COMMITTED;
			pend_hdr_q    <= 1'b0;
		end else begin
			state_q       <= state_d;
			peek_q        <= peek_d;
			pend_status_q <= pend_status_d;
			pend_hdr_q    <= pend_hdr_d;
		end
	end

endmodule

// ----- rtl/lprf_checker.sv -----
// ----------------------------------------------------------------------------
// lprf_checker
// Port-level checks on the result stream of the record FIFO.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lprf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lprf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [lprf_pkg::ST_W-1:0]        m_axis_tuser,
	input logic                             m_axis_tlast
);

	localparam int LEN_LO  = lprf_pkg::BYTE_W;
	localparam int USED_LO = LEN_LO + lprf_pkg::LEN_W;
	localparam int FREE_LO = USED_LO + lprf_pkg::CNT_W;

	logic [lprf_pkg::BYTE_W-1:0] chk_byte;
	logic [lprf_pkg::LEN_W-1:0]  chk_len;
	logic [lprf_pkg::CNT_W:0]    chk_sum;
	logic                        sum_ok, body_beat, body_len_ok, single_ok;

	assign chk_byte    = m_axis_tdata[lprf_pkg::BYTE_W-1:0];
	assign chk_len     = m_axis_tdata[USED_LO-1:LEN_LO];
	assign chk_sum     = {1'b0, m_axis_tdata[FREE_LO-1:USED_LO]} +
		{1'b0, m_axis_tdata[FREE_LO+lprf_pkg::CNT_W-1:FREE_LO]};
	assign sum_ok      = chk_sum == (lprf_pkg::CNT_W + 1)'(lprf_pkg::CAP_BYTES);
	assign body_beat   = m_axis_tvalid && (m_axis_tuser == lprf_pkg::ST_BODY);
	assign body_len_ok = (chk_len != '0) &&
		(chk_len <= lprf_pkg::LEN_W'(lprf_pkg::MAX_RECORD));
	assign single_ok   = m_axis_tlast && (chk_byte == '0);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_IMPLY(a_used_free_sum, clk, arst_n, m_axis_tvalid, sum_ok)
	`ASSERT_IMPLY(a_body_len, clk, arst_n, body_beat, body_len_ok)
	`ASSERT_IMPLY(a_single_beat, clk, arst_n, m_axis_tvalid && !body_beat, single_ok)

endmodule

bind length_prefixed_record_fifo_top lprf_checker u_lprf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
